// ===== sv/spq_pkg.sv =====
package spq_pkg;

   // Action codes carried by a request beat.
   localparam logic [1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [1:0] ACT_DEQUEUE = 2'd1;
   localparam logic [1:0] ACT_LIST    = 2'd2;

   // Status codes carried by a response beat.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Longest run of response beats that one list request may produce.
   localparam int MAX_RESULTS = 16;

   // One stored entry: item value and its priority.
   typedef struct packed {
      logic signed [31:0] val;
      logic signed [15:0] pri;
   } spq_entry_type;

   // Strobes from the sequencer to the entry store.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } spq_mem_ctl_type;

endpackage

// ===== sv/spq_req_if.sv =====
interface spq_req_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  action;
   logic signed [31:0] value_in;
   logic signed [15:0] priority_in;

   modport source (output valid, output action, output value_in, output priority_in,
                   input ready);
   modport sink (input valid, input action, input value_in, input priority_in,
                 output ready);
endinterface

// ===== sv/spq_rsp_if.sv =====
interface spq_rsp_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  status;
   logic signed [31:0] value_out;
   logic signed [15:0] priority_out;
   logic               last;

   modport source (output valid, output status, output value_out, output priority_out,
                   output last, input ready);
   modport sink (input valid, input status, input value_out, input priority_out,
                 input last, output ready);
endinterface

// ===== sv/spq_store.sv =====
module spq_store
   import spq_pkg::*;
#(
   parameter int CAPACITY = 16,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic            clock,
   input  spq_mem_ctl_type mem_ctl,
   input  logic [AW-1:0]   wr_addr,
   input  spq_entry_type   wr_data,
   input  logic [AW-1:0]   rd_addr,
   output spq_entry_type   rd_data_ff
);

   spq_entry_type mem [CAPACITY];

   // Single write port and one registered read port; the read data holds
   // until the next read strobe.
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/spq_ctrl.sv =====
module spq_ctrl
   import spq_pkg::*;
#(
   parameter int CAPACITY = 16,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  logic            clock,
   input  logic            reset,
   spq_req_if.sink         req_if,
   spq_rsp_if.source       rsp_if,
   output spq_mem_ctl_type mem_ctl,
   output logic [AW-1:0]   wr_addr,
   output spq_entry_type   wr_data,
   output logic [AW-1:0]   rd_addr,
   input  spq_entry_type   rd_data
);

   localparam int LIST_MAX = (CAPACITY < MAX_RESULTS) ? CAPACITY : MAX_RESULTS;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_CMP  = 3'd2;
   localparam logic [2:0] S_RESP = 3'd3;
   localparam logic [2:0] S_READ = 3'd4;
   localparam logic [2:0] S_DATA = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] end_ff, end_in;
   spq_entry_type new_ff, new_in;
   logic [1:0]    res_status_ff, res_status_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   spq_entry_type rsp_entry_ff, rsp_entry_in;
   logic          rsp_last_ff, rsp_last_in;

   logic          accept;
   logic          slot_free;
   logic          is_full;
   logic          is_empty;
   logic [CW-1:0] list_len;
   logic          pri_greater;

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;
   assign is_full      = (count_ff == CW'(CAPACITY));
   assign is_empty     = (count_ff == '0);
   assign list_len     = (count_ff > CW'(LIST_MAX)) ? CW'(LIST_MAX) : count_ff;

   // The shared comparator: does the stored entry sort after the new one?
   assign pri_greater = (rd_data.pri > new_ff.pri);

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.value_out    = rsp_entry_ff.val;
   assign rsp_if.priority_out = rsp_entry_ff.pri;
   assign rsp_if.last         = rsp_last_ff;

   // Sequencer. An enqueue walks down from the tail, moving each entry with
   // a larger priority up one place until the insertion point is found.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      end_in        = end_ff;
      new_in        = new_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_last_in   = rsp_last_ff;
      mem_ctl       = '0;
      wr_addr       = idx_ff;
      wr_data       = new_ff;
      rd_addr       = idx_ff;

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_if.action)
                  ACT_ENQUEUE: begin
                     if (is_full) begin
                        res_status_in = ST_FULL;
                        state_in      = S_RESP;
                     end else begin
                        new_in   = '{val: req_if.value_in, pri: req_if.priority_in};
                        idx_in   = count_ff[AW-1:0];
                        state_in = S_SCAN;
                     end
                  end
                  ACT_DEQUEUE: begin
                     if (is_empty) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_RESP;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = AW'(count_ff - 1'b1);
                        idx_in        = AW'(count_ff - 1'b1);
                        end_in        = AW'(count_ff - 1'b1);
                        count_in      = count_ff - 1'b1;
                        state_in      = S_DATA;
                     end
                  end
                  ACT_LIST: begin
                     if (is_empty) begin
                        res_status_in = ST_EMPTY;
                        state_in      = S_RESP;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = '0;
                        idx_in        = '0;
                        end_in        = AW'(list_len - 1'b1);
                        state_in      = S_DATA;
                     end
                  end
                  default: begin
                     // The spare action code is dropped without a response.
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (idx_ff == '0) begin
               mem_ctl.wr_en = 1'b1;
               wr_addr       = '0;
               count_in      = count_ff + 1'b1;
               res_status_in = ST_OK;
               state_in      = S_RESP;
            end else begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = idx_ff - 1'b1;
               state_in      = S_CMP;
            end
         end
         S_CMP: begin
            mem_ctl.wr_en = 1'b1;
            if (pri_greater) begin
               wr_data  = rd_data;
               idx_in   = idx_ff - 1'b1;
               state_in = S_SCAN;
            end else begin
               count_in      = count_ff + 1'b1;
               res_status_in = ST_OK;
               state_in      = S_RESP;
            end
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_READ: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = S_DATA;
         end
         S_DATA: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_entry_in  = rd_data;
               rsp_last_in   = (idx_ff == end_ff);
               if (idx_ff == end_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      end_ff        <= end_in;
      new_ff        <= new_in;
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

// ===== sv/sorted_priority_queue_top.sv =====
// Enqueue moves each entry that sorts after the new one up one place; list sends one beat per entry.
// One request is handled at a time, and a response beat may wait for the receiver.
// Response beats leave through an output register, so a new request is taken while one waits.
// Synchronous reset empties the queue and clears the sequencer and output valid;
// the entry store itself is not cleared.
module sorted_priority_queue_top
   import spq_pkg::*;
#(
   parameter int CAPACITY = 16,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_if,
   spq_rsp_if.source rsp_if
);

   spq_mem_ctl_type mem_ctl;
   logic [AW-1:0]   wr_addr;
   logic [AW-1:0]   rd_addr;
   spq_entry_type   wr_data;
   spq_entry_type   rd_data;

   // Sequencer with the shared priority comparator and the output register.
   spq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sorted entry storage, head at address zero.
   spq_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock      (clock),
      .mem_ctl    (mem_ctl),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import spq_pkg::*;

   // Action code three has no meaning for the block and must be dropped silently.
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam int CAPACITY    = 16;
   localparam int HOLD_CYCLES = 200;
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 60;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] val;
      logic signed [15:0] pri;
      logic               last;
   } rsp_beat_type;

   logic clock = 1'b0;
   logic reset;

   spq_req_if req_if ();
   spq_rsp_if rsp_if ();

   sorted_priority_queue_top #(.CAPACITY(CAPACITY)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Shadow copy of the queue contents, head at index zero.
   logic signed [31:0] shadow_val [CAPACITY];
   logic signed [15:0] shadow_pri [CAPACITY];
   int unsigned        shadow_count;

   rsp_beat_type expected_beats [$];
   int unsigned  error_count;
   bit           idle_on;
   logic         hold_trigger;
   int unsigned  hold_count;

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic push_beat(input logic [1:0] st, input logic signed [31:0] v,
                            input logic signed [15:0] p, input logic lst);
      rsp_beat_type b;
      b.status = st;
      b.val    = v;
      b.pri    = p;
      b.last   = lst;
      expected_beats.push_back(b);
   endtask

   // Work out the response beats of one accepted request and update the shadow queue.
   task automatic predict_queue_op(input logic [1:0] act, input logic signed [31:0] v,
                                   input logic signed [15:0] p);
      int unsigned pos;
      int unsigned n;
      case (act)
         ACT_ENQUEUE: begin
            if (shadow_count >= CAPACITY) begin
               push_beat(ST_FULL, '0, '0, 1'b1);
            end else begin
               pos = shadow_count;
               for (int i = 0; i < shadow_count; i++) begin
                  if (shadow_pri[i] > p) begin
                     pos = i;
                     break;
                  end
               end
               for (int i = shadow_count; i > pos; i--) begin
                  shadow_val[i] = shadow_val[i-1];
                  shadow_pri[i] = shadow_pri[i-1];
               end
               shadow_val[pos] = v;
               shadow_pri[pos] = p;
               shadow_count++;
               push_beat(ST_OK, '0, '0, 1'b1);
            end
         end
         ACT_DEQUEUE: begin
            if (shadow_count == 0) begin
               push_beat(ST_EMPTY, '0, '0, 1'b1);
            end else begin
               shadow_count--;
               push_beat(ST_OK, shadow_val[shadow_count], shadow_pri[shadow_count], 1'b1);
            end
         end
         ACT_LIST: begin
            n = (shadow_count > MAX_RESULTS) ? MAX_RESULTS : shadow_count;
            if (n == 0) begin
               push_beat(ST_EMPTY, '0, '0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++) begin
                  push_beat(ST_OK, shadow_val[i], shadow_pri[i], (i + 1 == n));
               end
            end
         end
         default: begin
            // Unused action: no beat, no change.
         end
      endcase
   endtask

   // Offer one request beat after a random gap and wait until it is taken.
   // Valid is left high on return so that back-to-back beats need no second assignment.
   task automatic send_item(input logic [1:0] act, input logic signed [31:0] v,
                            input logic signed [15:0] p);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.action      <= act;
      req_if.value_in    <= v;
      req_if.priority_in <= p;
      do @(posedge clock); while (!req_if.ready);
      predict_queue_op(act, v, p);
   endtask

   // Priorities drawn either from a narrow band, so that ties are common, or from the
   // whole range.
   function automatic logic signed [15:0] draw_priority();
      logic signed [15:0] p;
      if ($urandom_range(0, 1) == 0) begin
         p = 16'($urandom_range(0, 6));
         p = p - 16'sd3;
      end else begin
         p = 16'($urandom);
      end
      return p;
   endfunction

   task automatic send_random_item(input int unsigned enqueue_pct);
      int unsigned r;
      logic [1:0]  act;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         act = ACT_UNUSED;
      end else if (r < 3 + enqueue_pct) begin
         act = ACT_ENQUEUE;
      end else if (r < 15 + enqueue_pct) begin
         act = ACT_LIST;
      end else begin
         act = ACT_DEQUEUE;
      end
      send_item(act, $urandom, draw_priority());
   endtask

   task automatic test_empty_queue();
      send_item(ACT_LIST, 32'sd5, 16'sd1);
      send_item(ACT_DEQUEUE, 32'sd7, -16'sd1);
      send_item(ACT_UNUSED, 32'h7fff_ffff, 16'h7fff);
   endtask

   // Fill with extreme values and tied priorities, overflow once, list and take the tail.
   task automatic test_fill_to_capacity();
      send_item(ACT_ENQUEUE, 32'h7fff_ffff, 16'h8000);
      send_item(ACT_ENQUEUE, 32'h8000_0000, 16'h7fff);
      send_item(ACT_ENQUEUE, 32'h0000_0000, 16'h0000);
      send_item(ACT_ENQUEUE, 32'hffff_ffff, 16'hffff);
      send_item(ACT_ENQUEUE, 32'h0000_0001, 16'h0000);
      send_item(ACT_ENQUEUE, 32'h0000_0002, 16'h0000);
      send_item(ACT_ENQUEUE, 32'h5555_5555, 16'h7fff);
      send_item(ACT_ENQUEUE, 32'haaaa_aaaa, 16'h8000);
      send_item(ACT_ENQUEUE, 32'h1234_5678, 16'h0001);
      send_item(ACT_ENQUEUE, 32'h8765_4321, 16'h5555);
      send_item(ACT_ENQUEUE, 32'h0f0f_0f0f, 16'haaaa);
      send_item(ACT_ENQUEUE, 32'hf0f0_f0f0, 16'h7ffe);
      send_item(ACT_ENQUEUE, 32'h0000_0003, 16'h0000);
      send_item(ACT_ENQUEUE, 32'h7fff_fffe, 16'h8001);
      send_item(ACT_ENQUEUE, 32'h8000_0001, 16'hfffe);
      send_item(ACT_ENQUEUE, 32'hdead_0000, 16'h7fff);
      send_item(ACT_ENQUEUE, 32'h1111_1111, 16'h0000);
      send_item(ACT_LIST, '0, '0);
      send_item(ACT_DEQUEUE, '0, '0);
   endtask

   // The receiver stops for a long stretch while requests keep coming, so the block
   // fills its output and must stall its input.
   task automatic test_backpressure();
      hold_trigger <= 1'b1;
      @(posedge clock);
      hold_trigger <= 1'b0;
      send_item(ACT_LIST, '0, '0);
      send_item(ACT_DEQUEUE, '0, '0);
      for (int i = 0; i < 6; i++) begin
         send_random_item(60);
      end
      send_item(ACT_LIST, '0, '0);
   endtask

   // Phases lean towards filling or draining so that the queue swings between empty
   // and full; one phase runs without gaps on either side.
   task automatic test_random_traffic();
      for (int ph = 0; ph < 6; ph++) begin
         idle_on = (ph != 2);
         for (int i = 0; i < 15; i++) begin
            send_random_item((ph % 2 == 0) ? 70 : 20);
         end
      end
      idle_on = 1'b1;
   endtask

   // Receiver: a random gap after every accepted beat, plus the long hold-off.
   initial begin : rsp_ready_proc
      int unsigned gap;
      rsp_if.ready <= 1'b0;
      gap = 0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            gap = idle_on ? $urandom_range(0, 4) : 0;
         end else if (gap != 0) begin
            gap--;
         end
         rsp_if.ready <= (gap == 0) && (hold_count == 0) && !reset;
      end
   end

   // Counts down the receiver hold-off once triggered.
   initial begin : hold_off_proc
      hold_count <= 0;
      forever begin
         @(posedge clock);
         if (hold_trigger) begin
            hold_count <= HOLD_CYCLES;
         end else if (hold_count != 0) begin
            hold_count <= hold_count - 1;
         end
      end
   end

   // Compare every accepted response beat with the oldest expected one.
   initial begin : rsp_checker
      rsp_beat_type got;
      rsp_beat_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.status = rsp_if.status;
            got.val    = rsp_if.value_out;
            got.pri    = rsp_if.priority_out;
            got.last   = rsp_if.last;
            if (expected_beats.size() == 0) begin
               report_mismatch($sformatf("unexpected beat status %0d value %h priority %h",
                                         got.status, got.val, got.pri));
            end else begin
               want = expected_beats.pop_front();
               if (got.status !== want.status) begin
                  report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
               end
               if (got.val !== want.val) begin
                  report_mismatch($sformatf("value %h, want %h", got.val, want.val));
               end
               if (got.pri !== want.pri) begin
                  report_mismatch($sformatf("priority %h, want %h", got.pri, want.pri));
               end
               if (got.last !== want.last) begin
                  report_mismatch($sformatf("last %b, want %b", got.last, want.last));
               end
            end
         end
      end
   end

   // Ends the run if no beat moves on either side for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d beats outstanding",
                     quiet, expected_beats.size());
            $display("** sorted_priority_queue_top: FAILED **");
            $finish;
         end
      end
   end

   // Main sequence.
   initial begin
      error_count  = 0;
      shadow_count = 0;
      idle_on      = 1'b1;
      hold_trigger <= 1'b0;
      reset        <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.action      <= ACT_ENQUEUE;
      req_if.value_in    <= '0;
      req_if.priority_in <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_queue();
      test_fill_to_capacity();
      test_backpressure();
      test_random_traffic();

      // Drain: wait for every expected beat, then allow for trailing work.
      req_if.valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("** sorted_priority_queue_top: PASSED **");
      end else begin
         $display("** sorted_priority_queue_top: FAILED **");
      end
      $finish;
   end

endmodule
